// File: hdl/sprs_pkg.sv
// ----------------------------------------------------------------------------
// sprs_pkg : shared types and codes for the slotted page record store
// Opcodes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package sprs_pkg;

    typedef enum logic [1:0] {
        OP_STORE  = 2'd0,
        OP_READ   = 2'd1,
        OP_DELETE = 2'd2,
        OP_FORMAT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_NOSLOT  = 2'd2,
        ST_OFFSET  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ST_CHECK,
        S_ST_COPY_RD,
        S_ST_COPY_WR,
        S_RD_DIR,
        S_RD_DATA,
        S_RD_DONE,
        S_DL_DIR,
        S_DL_MOVE_RD,
        S_DL_MOVE_WR,
        S_DL_SHIFT_RD,
        S_DL_SHIFT_WR,
        S_DL_DONE,
        S_DL_GAP,
        S_DONE
    } state_t;

endpackage

// File: hdl/sprs_mem.sv
// ----------------------------------------------------------------------------
// sprs_mem : single-port synchronous memory
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module sprs_mem #(
    parameter int AW = 12,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [0:(1<<AW)-1];

    // read before write, data registered on read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: hdl/slotted_page_record_store.sv
// ----------------------------------------------------------------------------
// slotted_page_record_store : one slotted page behind a command port
// Sequencer over page, staging and directory memories with one shared adder.
// ----------------------------------------------------------------------------
// Channel    Direction  Signals
// command    in         start, busy (out), opcode, slot_index, byte_offset,
//                       data_byte, last_byte
// result     out        done, status, value, read_byte
//
// A store byte that is not last is only staged; a last byte also checks space
// and copies the record into the page byte by byte. A read looks up the slot,
// then the page byte. Delete moves each data byte, then shifts each later slot.
// Reset clears count and staging count and sets free end to PAGE_BYTES;
// memories need no clearing. The receiver cannot stall: done is high for one
// cycle per command, but not for a store byte that is not last.
module slotted_page_record_store #(
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_SLOTS  = 1023
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [9:0]  slot_index,
    input  logic [11:0] byte_offset,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        done,
    output logic [1:0]  status,
    output logic [12:0] value,
    output logic [7:0]  read_byte
);

    localparam int AW  = $clog2(PAGE_BYTES);
    localparam int SW  = $clog2(MAX_SLOTS);
    localparam int CW0 = $clog2(PAGE_BYTES + 1) + 2;
    localparam int CW  = (CW0 > 13) ? CW0 : 13;
    localparam int XW  = (SW + 1 > 10) ? SW + 1 : 10;

    sprs_pkg::state_t state_reg, state_next;

    logic [SW:0]   count_reg, count_next;
    logic [CW-1:0] free_reg, free_next;
    logic [AW:0]   stg_cnt_reg, stg_cnt_next;
    logic [CW-1:0] a_reg, a_next;       // working pointer / counter
    logic [CW-1:0] b_reg, b_next;       // second pointer / length
    logic [CW-1:0] c_reg, c_next;       // start of record
    logic [SW:0]   i_reg, i_next;
    logic [11:0]   off_reg, off_next;
    logic [7:0]    byte_reg, byte_next;
    logic [1:0]    st_reg, st_next;
    logic [12:0]   val_reg, val_next;
    logic [7:0]    rb_reg, rb_next;

    // memories
    logic          pg_we, sg_we, dr_we;
    logic [AW-1:0] pg_addr, sg_addr;
    logic [SW-1:0] dr_addr;
    logic [7:0]    pg_wd, pg_rd, sg_wd, sg_rd;
    logic [2*CW-1:0] dr_wd, dr_rd;

    sprs_mem #(.AW(AW), .DW(8)) u_page (
        .clk(clk), .we(pg_we), .addr(pg_addr), .wdata(pg_wd), .rdata(pg_rd));
    sprs_mem #(.AW(AW), .DW(8)) u_stage (
        .clk(clk), .we(sg_we), .addr(sg_addr), .wdata(sg_wd), .rdata(sg_rd));
    sprs_mem #(.AW(SW), .DW(2*CW)) u_dir (
        .clk(clk), .we(dr_we), .addr(dr_addr), .wdata(dr_wd), .rdata(dr_rd));

    // shared adder
    logic [CW-1:0] add_a, add_b, add_y;
    assign add_y = add_a + add_b;

    logic [CW-1:0] dir_start, dir_len;
    assign dir_start = dr_rd[2*CW-1:CW];
    assign dir_len   = dr_rd[CW-1:0];

    // slot lookup beyond the record count
    logic slot_absent;
    assign slot_absent = XW'(slot_index) >= XW'(count_reg);

    // delete moves data only when the record lies inside the used area
    logic dir_start_ok, dir_start_ok_next, dir_start_ok_reg;
    logic [CW-1:0] need;
    assign need = CW'({count_reg, 2'b00}) + CW'(8) + b_reg;
    assign dir_start_ok = dir_start_ok_reg;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sprs_pkg::S_IDLE;
            count_reg   <= '0;
            free_reg    <= CW'(PAGE_BYTES);
            stg_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            free_reg    <= free_next;
            stg_cnt_reg <= stg_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        i_reg    <= i_next;
        off_reg  <= off_next;
        byte_reg <= byte_next;
        st_reg   <= st_next;
        val_reg  <= val_next;
        rb_reg   <= rb_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sprs_pkg::S_IDLE:
            begin
                if (start)
                begin
                    unique case (sprs_pkg::op_t'(opcode))
                        sprs_pkg::OP_STORE:
                            state_next = last_byte ? sprs_pkg::S_ST_CHECK
                                                   : sprs_pkg::S_IDLE;
                        sprs_pkg::OP_READ:
                            state_next = slot_absent
                                ? sprs_pkg::S_DONE : sprs_pkg::S_RD_DIR;
                        sprs_pkg::OP_DELETE:
                            state_next = slot_absent
                                ? sprs_pkg::S_DONE : sprs_pkg::S_DL_DIR;
                        default:
                            state_next = sprs_pkg::S_DONE;
                    endcase
                end
            end
            sprs_pkg::S_ST_CHECK:
                state_next = (st_next == sprs_pkg::ST_OK && b_reg != 0)
                    ? sprs_pkg::S_ST_COPY_RD : sprs_pkg::S_DONE;
            sprs_pkg::S_ST_COPY_RD:
                state_next = sprs_pkg::S_ST_COPY_WR;
            sprs_pkg::S_ST_COPY_WR:
                state_next = (a_reg + 1'b1 == b_reg) ? sprs_pkg::S_DONE
                                                     : sprs_pkg::S_ST_COPY_RD;
            sprs_pkg::S_RD_DIR:
                state_next = sprs_pkg::S_RD_DATA;
            sprs_pkg::S_RD_DATA:
                state_next = sprs_pkg::S_RD_DONE;
            sprs_pkg::S_RD_DONE:
                state_next = sprs_pkg::S_DONE;
            sprs_pkg::S_DL_DIR:
                state_next = sprs_pkg::S_DL_MOVE_RD;
            sprs_pkg::S_DL_MOVE_RD:
                state_next = (b_reg == 0 || a_reg == free_reg
                              || dir_start_ok == 1'b0)
                    ? sprs_pkg::S_DL_SHIFT_RD : sprs_pkg::S_DL_MOVE_WR;
            sprs_pkg::S_DL_MOVE_WR:
                state_next = sprs_pkg::S_DL_MOVE_RD;
            sprs_pkg::S_DL_SHIFT_RD:
                state_next = (i_reg + 1'b1 >= count_reg) ? sprs_pkg::S_DL_DONE
                                                         : sprs_pkg::S_DL_SHIFT_WR;
            sprs_pkg::S_DL_SHIFT_WR:
                state_next = sprs_pkg::S_DL_SHIFT_RD;
            sprs_pkg::S_DL_DONE:
                state_next = sprs_pkg::S_DL_GAP;
            sprs_pkg::S_DL_GAP:
                state_next = sprs_pkg::S_DONE;
            sprs_pkg::S_DONE:
                state_next = sprs_pkg::S_IDLE;
            default:
                state_next = sprs_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next   = count_reg;
        free_next    = free_reg;
        stg_cnt_next = stg_cnt_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg; i_next = i_reg;
        off_next = off_reg; byte_next = byte_reg;
        st_next = st_reg; val_next = val_reg; rb_next = rb_reg;
        dir_start_ok_next = dir_start_ok_reg;
        pg_we = 1'b0; sg_we = 1'b0; dr_we = 1'b0;
        pg_addr = a_reg[AW-1:0]; sg_addr = a_reg[AW-1:0]; dr_addr = i_reg[SW-1:0];
        pg_wd = byte_reg; sg_wd = data_byte; dr_wd = {c_reg, b_reg};
        add_a = a_reg; add_b = CW'(1);
        unique case (state_reg)
            sprs_pkg::S_IDLE:
            begin
                st_next = sprs_pkg::ST_OK; val_next = '0; rb_next = '0;
                i_next = (SW+1)'(slot_index); off_next = byte_offset;
                dr_addr = SW'(slot_index);
                sg_addr = stg_cnt_reg[AW-1:0];
                if (start)
                begin
                    unique case (sprs_pkg::op_t'(opcode)) inside
                        sprs_pkg::OP_STORE:
                        begin
                            add_a = CW'(stg_cnt_reg);
                            if (stg_cnt_reg < (AW+1)'(PAGE_BYTES))
                            begin
                                sg_we = 1'b1;
                                stg_cnt_next = add_y[AW:0];
                            end
                            b_next = (stg_cnt_reg < (AW+1)'(PAGE_BYTES))
                                ? add_y : CW'(stg_cnt_reg);
                        end
                        sprs_pkg::OP_READ, sprs_pkg::OP_DELETE:
                            if (slot_absent)
                                st_next = sprs_pkg::ST_NOSLOT;
                        default:
                        begin
                            count_next = '0;
                            free_next  = CW'(PAGE_BYTES);
                        end
                    endcase
                end
            end
            sprs_pkg::S_ST_CHECK:
            begin
                stg_cnt_next = '0;
                add_a = free_reg; add_b = ~b_reg + 1'b1;
                c_next = add_y;               // base = free_end - len
                a_next = '0;
                if (count_reg >= (SW+1)'(MAX_SLOTS) || need > free_reg)
                begin
                    st_next = sprs_pkg::ST_NOSPACE;
                end
                else
                begin
                    dr_addr = count_reg[SW-1:0];
                    dr_wd = {add_y, b_reg};
                    dr_we = 1'b1;
                    count_next = count_reg + 1'b1;
                    free_next  = add_y;
                    val_next   = 13'(count_reg + 1'b1);
                end
            end
            sprs_pkg::S_ST_COPY_RD:
                sg_addr = a_reg[AW-1:0];
            sprs_pkg::S_ST_COPY_WR:
            begin
                add_a = c_reg; add_b = a_reg;
                pg_addr = add_y[AW-1:0]; pg_wd = sg_rd; pg_we = 1'b1;
                a_next = a_reg + 1'b1;
            end
            sprs_pkg::S_RD_DIR: ;
            sprs_pkg::S_RD_DATA:
            begin
                add_a = dir_start; add_b = CW'(off_reg);
                pg_addr = add_y[AW-1:0];
                val_next = 13'(dir_len);
                if (CW'(off_reg) >= dir_len || add_y >= CW'(PAGE_BYTES))
                    st_next = sprs_pkg::ST_OFFSET;
            end
            sprs_pkg::S_RD_DONE:
                if (st_reg == sprs_pkg::ST_OK)
                    rb_next = pg_rd;
            sprs_pkg::S_DL_DIR:
            begin
                // a: source pointer walking down from start-1, b: len
                b_next = dir_len; c_next = dir_start;
                a_next = dir_start; pg_addr = dir_start[AW-1:0] - 1'b1;
                add_a = dir_start; add_b = dir_len;
                dir_start_ok_next = dir_start >= free_reg
                                    && add_y <= CW'(PAGE_BYTES);
            end
            sprs_pkg::S_DL_MOVE_RD:
            begin
                // read byte at a-1 (ready next cycle)
                add_a = a_reg; add_b = '1;
                pg_addr = add_y[AW-1:0];
            end
            sprs_pkg::S_DL_MOVE_WR:
            begin
                add_a = a_reg; add_b = b_reg - 1'b1;
                pg_addr = add_y[AW-1:0]; pg_wd = pg_rd; pg_we = 1'b1;
                a_next = a_reg - 1'b1;
            end
            sprs_pkg::S_DL_SHIFT_RD:
            begin
                add_a = CW'(i_reg); add_b = CW'(1);
                dr_addr = add_y[SW-1:0];
            end
            sprs_pkg::S_DL_SHIFT_WR:
            begin
                add_a = dir_start; add_b = b_reg;
                dr_addr = i_reg[SW-1:0]; dr_wd = {add_y, dir_len}; dr_we = 1'b1;
                i_next = i_reg + 1'b1;
            end
            sprs_pkg::S_DL_DONE:
            begin
                add_a = free_reg; add_b = b_reg;
                count_next = count_reg - 1'b1;
                free_next = (add_y > CW'(PAGE_BYTES)) ? CW'(PAGE_BYTES) : add_y;
                // header plus the remaining directory: 4 * old count
                a_next = CW'({count_reg, 2'b00});
            end
            sprs_pkg::S_DL_GAP:
            begin
                add_a = free_reg; add_b = ~a_reg + 1'b1;
                val_next = (free_reg >= a_reg) ? add_y[12:0] : '0;
            end
            sprs_pkg::S_DONE: ;
            default: ;
        endcase
    end

    // delete start-range flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_start_ok_reg <= 1'b0;
        end
        else
        begin
            dir_start_ok_reg <= dir_start_ok_next;
        end
    end

    // outputs
    always_comb
    begin
        busy      = (state_reg != sprs_pkg::S_IDLE);
        done      = (state_reg == sprs_pkg::S_DONE);
        status    = st_reg;
        value     = val_reg;
        read_byte = rb_reg;
    end

endmodule

// File: tb/slotted_page_record_store_tb.sv
// ----------------------------------------------------------------------------
// slotted_page_record_store_tb : self-checking bench for the slotted page
// Drives store, read, delete and format commands, predicts every result
// from a behavioural page image and compares each done transaction.
// ----------------------------------------------------------------------------
module slotted_page_record_store_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE     = 4096;
    localparam int SLOTS    = 1023;
    localparam int WD_LIMIT = 100000;

    typedef struct {
        sprs_pkg::status_t st;
        logic [12:0]       val;
        logic [7:0]        rbyte;
    } page_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [9:0]  slot_index;
    logic [11:0] byte_offset;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        done;
    logic [1:0]  status;
    logic [12:0] value;
    logic [7:0]  read_byte;

    // behavioural page image
    int          pg_count;
    int          pg_free_end;
    int          pg_stage_cnt;
    int          pg_start [SLOTS];
    int          pg_len   [SLOTS];
    logic [7:0]  pg_bytes [PAGE];
    logic [7:0]  pg_stage [PAGE];

    page_result_t pending_results[$];
    int          fail_count;
    int          items_sent;
    int          results_seen;
    int          idle_pct;
    int          quiet_cycles;

    slotted_page_record_store dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .slot_index  (slot_index),
        .byte_offset (byte_offset),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .done        (done),
        .status      (status),
        .value       (value),
        .read_byte   (read_byte)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // page behaviour for one accepted command
    function automatic void predict_page(input sprs_pkg::op_t op, input int slot,
                                         input int off, input logic [7:0] dbyte,
                                         input logic last);
        page_result_t r;
        int len;
        int base;
        int s;
        int gap;
        r.st    = sprs_pkg::ST_OK;
        r.val   = '0;
        r.rbyte = '0;
        case (op)
            sprs_pkg::OP_STORE:
            begin
                if (pg_stage_cnt < PAGE)
                begin
                    pg_stage[pg_stage_cnt] = dbyte;
                    pg_stage_cnt++;
                end
                if (!last)
                    return;
                len          = pg_stage_cnt;
                pg_stage_cnt = 0;
                if (pg_count >= SLOTS || 4 * (pg_count + 2) + len > pg_free_end)
                    r.st = sprs_pkg::ST_NOSPACE;
                else
                begin
                    base = pg_free_end - len;
                    for (int i = 0; i < len; i++)
                        pg_bytes[base + i] = pg_stage[i];
                    pg_start[pg_count] = base;
                    pg_len[pg_count]   = len;
                    pg_count++;
                    pg_free_end = base;
                    r.val = 13'(pg_count);
                end
            end
            sprs_pkg::OP_READ:
            begin
                if (slot >= pg_count)
                    r.st = sprs_pkg::ST_NOSLOT;
                else
                begin
                    r.val = 13'(pg_len[slot]);
                    if (off >= pg_len[slot] || pg_start[slot] + off >= PAGE)
                        r.st = sprs_pkg::ST_OFFSET;
                    else
                        r.rbyte = pg_bytes[pg_start[slot] + off];
                end
            end
            sprs_pkg::OP_DELETE:
            begin
                if (slot >= pg_count)
                    r.st = sprs_pkg::ST_NOSLOT;
                else
                begin
                    s   = pg_start[slot];
                    len = pg_len[slot];
                    // slide the data below the record up by its length
                    if (s >= pg_free_end && s + len <= PAGE)
                        for (int i = s - pg_free_end - 1; i >= 0; i--)
                            pg_bytes[pg_free_end + len + i] = pg_bytes[pg_free_end + i];
                    for (int i = slot; i + 1 < pg_count; i++)
                    begin
                        pg_start[i] = pg_start[i + 1] + len;
                        pg_len[i]   = pg_len[i + 1];
                    end
                    pg_count--;
                    pg_free_end += len;
                    if (pg_free_end > PAGE)
                        pg_free_end = PAGE;
                    gap   = 4 + 4 * pg_count;
                    r.val = (pg_free_end >= gap) ? 13'(pg_free_end - gap) : 13'd0;
                end
            end
            default:
            begin
                pg_count    = 0;
                pg_free_end = PAGE;
            end
        endcase
        pending_results.push_back(r);
    endfunction

    // result check first, then prediction of any transaction accepted at this edge
    always @(posedge clk)
    begin
        page_result_t e;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d value=%0d byte=%0d",
                         $time, status, value, read_byte);
                fail_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    fail_count++;
                end
                if (value !== e.val)
                begin
                    $display("%0t: value expected %0d actual %0d", $time, e.val, value);
                    fail_count++;
                end
                if (read_byte !== e.rbyte)
                begin
                    $display("%0t: read_byte expected %0d actual %0d",
                             $time, e.rbyte, read_byte);
                    fail_count++;
                end
            end
        end
        if (rst_n && start && !busy)
            predict_page(sprs_pkg::op_t'(opcode), int'(slot_index), int'(byte_offset),
                         data_byte, last_byte);
    end

    // watchdog on cycles with no transaction either way
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("%0t: timeout, nothing accepted for %0d cycles", $time, WD_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // one command transaction; entered and left at a falling edge
    task automatic send_cmd(input sprs_pkg::op_t op, input int slot, input int off,
                            input int dbyte, input int last);
        if ($urandom_range(99) < idle_pct)
            repeat ($urandom_range(1, 6)) @(negedge clk);
        opcode      = op;
        slot_index  = 10'(slot);
        byte_offset = 12'(off);
        data_byte   = 8'(dbyte);
        last_byte   = 1'(last);
        start       = 1'b1;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        start = 1'b0;
        items_sent++;
    endtask

    task automatic store_record(input int len);
        for (int i = 0; i < len; i++)
            send_cmd(sprs_pkg::OP_STORE, $urandom_range(1023), $urandom_range(4095),
                     $urandom_range(255), int'(i == len - 1));
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0 || busy)
            @(negedge clk);
    endtask

    // stores, reads at the record edges, bad slot and bad offset
    task automatic test_store_read();
        send_cmd(sprs_pkg::OP_STORE, 0, 0, 8'h00, 1);
        send_cmd(sprs_pkg::OP_STORE, 0, 0, 8'hFF, 0);
        send_cmd(sprs_pkg::OP_STORE, 0, 0, 8'hA5, 1);
        send_cmd(sprs_pkg::OP_READ, 0, 0, 0, 0);
        send_cmd(sprs_pkg::OP_READ, 1, 1, 0, 0);
        send_cmd(sprs_pkg::OP_READ, 1, 2, 0, 0);
        send_cmd(sprs_pkg::OP_READ, 1, 4095, 0, 0);
        send_cmd(sprs_pkg::OP_READ, 2, 0, 0, 0);
        send_cmd(sprs_pkg::OP_READ, 1022, 0, 0, 0);
        send_cmd(sprs_pkg::OP_DELETE, 1022, 0, 0, 0);
    endtask

    // one-byte records until the directory and data meet and the page refuses
    task automatic test_fill_no_space();
        for (int i = 0; i < 820; i++)
            store_record(1);
        send_cmd(sprs_pkg::OP_READ, 2, 899, 0, 0);
        send_cmd(sprs_pkg::OP_DELETE, 0, 0, 0, 0);
        store_record(1);
    endtask

    // compaction of front, middle and last slots
    task automatic test_delete();
        send_cmd(sprs_pkg::OP_FORMAT, 0, 0, 0, 0);
        for (int i = 0; i < 5; i++)
            store_record(3 + i);
        send_cmd(sprs_pkg::OP_DELETE, 2, 0, 0, 0);
        send_cmd(sprs_pkg::OP_DELETE, 0, 0, 0, 0);
        send_cmd(sprs_pkg::OP_DELETE, 2, 0, 0, 0);
        for (int i = 0; i < 5; i++)
            send_cmd(sprs_pkg::OP_READ, i % 2, i, 0, 0);
    endtask

    // format keeps staged bytes
    task automatic test_format_staging();
        send_cmd(sprs_pkg::OP_FORMAT, 0, 0, 0, 0);
        send_cmd(sprs_pkg::OP_STORE, 0, 0, 8'h3C, 0);
        send_cmd(sprs_pkg::OP_FORMAT, 1022, 4095, 8'hFF, 1);
        send_cmd(sprs_pkg::OP_STORE, 0, 0, 8'hC3, 1);
        send_cmd(sprs_pkg::OP_READ, 0, 1, 0, 0);
    endtask

    // mostly well-formed records and lookups, some noise
    task automatic test_random(input int n);
        int sel;
        int slot;
        int target;
        target = items_sent + n;
        while (items_sent < target)
        begin
            sel = $urandom_range(99);
            if (sel < 40)
                store_record(($urandom_range(19) == 0) ? $urandom_range(200, 600)
                                                       : $urandom_range(1, 12));
            else if (sel < 80 && pg_count > 0)
            begin
                slot = $urandom_range(pg_count - 1);
                send_cmd(sprs_pkg::OP_READ, slot,
                         ($urandom_range(9) == 0) ? $urandom_range(4095)
                                                  : $urandom_range(pg_len[slot] - 1),
                         $urandom_range(255), $urandom_range(1));
            end
            else if (sel < 90 && pg_count > 0)
                send_cmd(sprs_pkg::OP_DELETE, $urandom_range(pg_count - 1),
                         $urandom_range(4095), $urandom_range(255), $urandom_range(1));
            else if (sel < 98)
                send_cmd(sprs_pkg::op_t'($urandom_range(1, 2)), $urandom_range(1023),
                         $urandom_range(4095), $urandom_range(255), $urandom_range(1));
            else
                send_cmd(sprs_pkg::OP_FORMAT, $urandom_range(1023), $urandom_range(4095),
                         $urandom_range(255), $urandom_range(1));
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        opcode       = '0;
        slot_index   = '0;
        byte_offset  = '0;
        data_byte    = '0;
        last_byte    = 1'b0;
        fail_count   = 0;
        items_sent   = 0;
        results_seen = 0;
        idle_pct     = 0;
        pg_count     = 0;
        pg_free_end  = PAGE;
        pg_stage_cnt = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_store_read();
        test_fill_no_space();
        test_delete();
        test_format_staging();
        idle_pct = 25;
        test_random(250);
        idle_pct = 72;
        test_random(250);
        idle_pct = 0;
        test_random(250);

        wait_drained();
        repeat (50) @(negedge clk);
        $display("Covered %0d commands and %0d results: stores, reads, deletes, formats,",
                 items_sent, results_seen);
        $display("full page, staging kept over format and bad slot and offset lookups.");
        if (fail_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
